### src/sitc_pkg.sv
// Shared constants of the spiral index to coordinate core.
// Fixed stream field widths; no dependencies.
`timescale 1ns / 1ps

package sitc_pkg;

    localparam int SIDE_W    = 16;                // side field / row and column fields
    localparam int INDEX_W   = 32;                // index field
    localparam int S_TDATA_W = SIDE_W + INDEX_W;  // side, index
    localparam int M_TDATA_W = 2 * SIDE_W;        // row, column

endpackage

### src/sitc_mult.sv
// Shared multiplier of the spiral index to coordinate core, registered product.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module sitc_mult #(
    parameter int W = 16
) (
    input  logic             clk,
    input  logic             start,
    input  logic [W-1:0]     a,
    input  logic [W-1:0]     b,
    output logic [2*W-1:0]   prod
);

    logic [2*W-1:0] prod_reg;

    // Hold the product until the sequencer issues the next operation.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= {{W{1'b0}}, a} * {{W{1'b0}}, b};
        end
    end

    assign prod = prod_reg;

endmodule

### src/sitc_edge.sv
// Edge selection of the spiral index to coordinate core: maps ring number,
// ring edge length and position inside the ring to a 1-based row and column.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module sitc_edge #(
    parameter int SW = 16
) (
    input  logic [SW-1:0]   k,
    input  logic [SW-1:0]   s,
    input  logic [SW+1:0]   p,
    output logic [SW-1:0]   row1,
    output logic [SW-1:0]   col1
);

    localparam int EW = SW + 2;

    logic [EW-1:0] k_e;
    logic [EW-1:0] s_e;
    logic [EW-1:0] r_e;
    logic [EW-1:0] c_e;

    assign k_e = {2'b00, k};
    assign s_e = {2'b00, s};

    always_comb
    begin
        if (p <= s_e)
        begin
            // top edge, left to right
            r_e = k_e;
            c_e = k_e + p - EW'(1);
        end
        else if (p <= (s_e << 1) - EW'(1))
        begin
            // right edge, downward
            r_e = k_e + p - s_e;
            c_e = k_e + s_e - EW'(1);
        end
        else if (p <= (s_e << 1) + s_e - EW'(2))
        begin
            // bottom edge, right to left
            r_e = k_e + s_e - EW'(1);
            c_e = k_e + (s_e << 1) + s_e - EW'(2) - p;
        end
        else
        begin
            // left edge, upward
            r_e = k_e + (s_e << 2) - EW'(3) - p;
            c_e = k_e;
        end
    end

    assign row1 = SW'(r_e + EW'(1));
    assign col1 = SW'(c_e + EW'(1));

endmodule

### src/spiral_index_to_coordinate_core.sv
// Top level of the spiral index to coordinate core: sequencer, search state,
// result register. Depends on sitc_pkg, sitc_mult and sitc_edge.
`timescale 1ns / 1ps

// Usage
//   Slave stream s_*: one beat carries a query, tdata = {index, side}.
//   Master stream m_*: one beat per query, tdata = {column, row} (1-based),
//   tuser = out_of_range. An index of zero or above side squared returns
//   row = column = 0 with out_of_range set.
// Sequencing
//   One query is worked on at a time; s_tready is high only while idle.
//   A query first squares the side and range checks, then runs a binary
//   search over the rings, each step one pass through the shared multiplier
//   plus one compare, and ends with edge selection.
//   Out of range queries finish after the check.
//   Every search step runs through the single multiplier.
// Stalls
//   The result sits in an output register; a new query is accepted while it
//   waits. A finished query holds in the sequencer until that register frees.
// Reset
//   rst_n clears the sequencer and the output valid; no query is in flight.
//   Only the low SIDE_BITS bits of side are used, at most 16.

module spiral_index_to_coordinate_core #(
    parameter int SIDE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sitc_pkg::S_TDATA_W-1:0]  s_tdata,   // [15:0] side, [47:16] index
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sitc_pkg::M_TDATA_W-1:0]  m_tdata,   // [15:0] row, [31:16] column
    output logic                            m_tuser    // [0] out_of_range
);

    localparam int SW = (SIDE_BITS < sitc_pkg::SIDE_W) ? SIDE_BITS : sitc_pkg::SIDE_W;
    localparam int IW = sitc_pkg::INDEX_W;
    // compare width: holds 4*k*(side-k), side*side and the index
    localparam int CW = (2 * SW + 2 > IW) ? 2 * SW + 2 : IW + 1;
    localparam int EW = SW + 2;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_MID  = 3'd3;
    localparam logic [2:0] ST_CMP  = 3'd4;
    localparam logic [2:0] ST_EDGE = 3'd5;

    logic [2:0]     state_reg, state_next;
    logic [SW-1:0]  side_reg, side_next;
    logic [IW-1:0]  idx_reg, idx_next;
    logic [SW-1:0]  lo_reg, lo_next;
    logic [SW-1:0]  hi_reg, hi_next;
    logic [SW-1:0]  mid_reg, mid_next;
    logic [CW-1:0]  base_reg, base_next;

    logic           out_valid_reg, out_valid_next;
    logic [SW-1:0]  row_reg, row_next;
    logic [SW-1:0]  col_reg, col_next;
    logic           oor_reg, oor_next;

    logic           s_beat;
    logic           out_free;
    logic           mul_start;
    logic [SW-1:0]  mul_a;
    logic [SW-1:0]  mul_b;
    logic [2*SW-1:0] prod;
    logic [CW-1:0]  prod_ext;
    logic [CW-1:0]  cb_ext;
    logic [CW-1:0]  idx_ext;
    logic [SW-1:0]  mid_calc;
    logic [SW-1:0]  ring_s;
    logic [EW-1:0]  ring_p;
    logic [SW-1:0]  edge_row1;
    logic [SW-1:0]  edge_col1;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_beat   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign prod_ext = CW'(prod);
    assign cb_ext   = CW'(prod) << 2;       // 4*mid*(side-mid)
    assign idx_ext  = CW'(idx_reg);
    assign mid_calc = SW'((lo_reg + hi_reg + SW'(1)) >> 1);

    // Shared multiplier: side*side for the range check, then mid*(side-mid).
    assign mul_start = (state_reg == ST_SQ) || (state_reg == ST_MID);
    assign mul_a     = (state_reg == ST_SQ) ? side_reg : mid_calc;
    assign mul_b     = (state_reg == ST_SQ) ? side_reg : SW'(side_reg - mid_calc);

    sitc_mult #(
        .W      (SW)
    ) u_mult (
        .clk    (clk),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .prod   (prod)
    );

    // Ring found: edge length and 1-based position inside the ring.
    assign ring_s = SW'(side_reg - (lo_reg << 1));
    assign ring_p = EW'(idx_ext - base_reg);

    sitc_edge #(
        .SW     (SW)
    ) u_edge (
        .k      (lo_reg),
        .s      (ring_s),
        .p      (ring_p),
        .row1   (edge_row1),
        .col1   (edge_col1)
    );

    always_comb
    begin
        state_next     = state_reg;
        side_next      = side_reg;
        idx_next       = idx_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        base_next      = base_reg;
        out_valid_next = out_valid_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        oor_next       = oor_reg;

        // drop the result once taken
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_beat)
                begin
                    side_next  = s_tdata[SW-1:0];
                    idx_next   = s_tdata[sitc_pkg::SIDE_W +: IW];
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if ((idx_reg == '0) || (idx_ext > prod_ext))
                begin
                    // index zero or past the last cell
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        row_next       = '0;
                        col_next       = '0;
                        oor_next       = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    lo_next   = '0;
                    hi_next   = SW'((side_reg - SW'(1)) >> 1);
                    base_next = '0;
                    if (side_reg > SW'(2))
                    begin
                        state_next = ST_MID;
                    end
                    else
                    begin
                        state_next = ST_EDGE;
                    end
                end
            end
            ST_MID:
            begin
                mid_next   = mid_calc;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                // advance the search: keep the largest ring whose preceding count is below index
                if (cb_ext < idx_ext)
                begin
                    lo_next   = mid_reg;
                    base_next = cb_ext;
                end
                else
                begin
                    hi_next = SW'(mid_reg - SW'(1));
                end
                if (lo_next < hi_next)
                begin
                    state_next = ST_MID;
                end
                else
                begin
                    state_next = ST_EDGE;
                end
            end
            ST_EDGE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    row_next       = edge_row1;
                    col_next       = edge_col1;
                    oor_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and search registers: no reset needed
    always_ff @(posedge clk)
    begin
        side_reg <= side_next;
        idx_reg  <= idx_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        base_reg <= base_next;
        row_reg  <= row_next;
        col_reg  <= col_next;
        oor_reg  <= oor_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {sitc_pkg::SIDE_W'(col_reg), sitc_pkg::SIDE_W'(row_reg)};
    assign m_tuser  = oor_reg;

endmodule

### dv/tb_top.sv
// Self-checking testbench for spiral_index_to_coordinate_core: directed and random
// spiral queries checked against an in-bench cell locator.
// Depends on sitc_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int SIDE_W    = sitc_pkg::SIDE_W;
    localparam int INDEX_W   = sitc_pkg::INDEX_W;
    localparam int S_TDATA_W = sitc_pkg::S_TDATA_W;
    localparam int M_TDATA_W = sitc_pkg::M_TDATA_W;

    typedef struct {
        logic [SIDE_W-1:0]  side;
        logic [INDEX_W-1:0] index;
        bit                 drain_first;  // hold this beat until no result is outstanding
    } query_t;

    typedef struct {
        logic [SIDE_W-1:0] row;
        logic [SIDE_W-1:0] column;
        logic              out_of_range;
    } cell_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    query_t pending_queries[$];
    cell_t  expected_cells[$];

    int unsigned queries_accepted = 0;
    int unsigned cells_checked    = 0;
    int unsigned misses_checked   = 0;
    int unsigned error_count      = 0;

    spiral_index_to_coordinate_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Cells lying on the rings outside ring k.
    function automatic longint unsigned ring_start(longint unsigned n, longint unsigned k);
        return 4 * k * (n - k);
    endfunction

    // Locate a 1-based spiral index on a side x side grid.
    function automatic cell_t locate_cell(logic [SIDE_W-1:0] side, logic [INDEX_W-1:0] index);
        longint unsigned n, idx, lo, hi, mid, k, s, p, r, c;
        cell_t loc;
        n   = 64'(side);
        idx = 64'(index);
        loc.row          = '0;
        loc.column       = '0;
        loc.out_of_range = 1'b1;
        if (idx == 0 || idx > n * n)
            return loc;
        // largest ring whose outer cells number less than the index
        lo = 0;
        hi = (n - 1) / 2;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (ring_start(n, mid) < idx)
                lo = mid;
            else
                hi = mid - 1;
        end
        k = lo;
        s = n - 2 * k;
        p = idx - ring_start(n, k);
        if (p <= s)
        begin
            r = k;
            c = k + p - 1;
        end
        else if (p <= 2 * s - 1)
        begin
            r = k + (p - s);
            c = k + s - 1;
        end
        else if (p <= 3 * s - 2)
        begin
            r = k + s - 1;
            c = k + s - 1 - (p - (2 * s - 1));
        end
        else
        begin
            r = k + s - 1 - (p - (3 * s - 2));
            c = k;
        end
        loc.row          = SIDE_W'(r + 1);
        loc.column       = SIDE_W'(c + 1);
        loc.out_of_range = 1'b0;
        return loc;
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_query(logic [SIDE_W-1:0] side, logic [INDEX_W-1:0] index,
                             bit drain_first = 1'b0);
        query_t q;
        q.side        = side;
        q.index       = index;
        q.drain_first = drain_first;
        pending_queries.push_back(q);
    endtask

    // Driver: present queued queries on the slave stream, with random gaps.
    int unsigned send_gap   = 0;
    bit          send_calm  = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_cells.push_back(locate_cell(s_tdata[SIDE_W-1:0],
                                                     s_tdata[SIDE_W +: INDEX_W]));
                queries_accepted++;
            end
            if ($urandom_range(0, 63) == 0)
                send_calm <= ~send_calm;
            // hold a beat the core has not taken yet
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_queries.size() != 0 &&
                         !(pending_queries[0].drain_first && expected_cells.size() != 0))
                begin
                    query_t q;
                    q = pending_queries.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {q.index, q.side};
                    send_gap <= send_calm ? 0 : pick_gap();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall the master stream at random and check every result beat.
    int unsigned sink_hold = 0;
    bit          sink_calm = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin : sink
        cell_t       want;
        int unsigned g;
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            sink_hold <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_cells.size() == 0)
                begin
                    $error("result beat with nothing outstanding: tdata=%h tuser=%b",
                           m_tdata, m_tuser);
                    error_count++;
                end
                else
                begin
                    want = expected_cells.pop_front();
                    if (m_tdata[SIDE_W-1:0] !== want.row)
                    begin
                        $error("row: expected %0d, got %0d", want.row, m_tdata[SIDE_W-1:0]);
                        error_count++;
                    end
                    if (m_tdata[SIDE_W +: SIDE_W] !== want.column)
                    begin
                        $error("column: expected %0d, got %0d", want.column,
                               m_tdata[SIDE_W +: SIDE_W]);
                        error_count++;
                    end
                    if (m_tuser !== want.out_of_range)
                    begin
                        $error("out_of_range: expected %b, got %b", want.out_of_range,
                               m_tuser);
                        error_count++;
                    end
                    if (want.out_of_range)
                        misses_checked++;
                    else
                        cells_checked++;
                end
            end
            if ($urandom_range(0, 63) == 0)
                sink_calm <= ~sink_calm;
            if (sink_hold > 0)
            begin
                m_tready  <= 1'b0;
                sink_hold <= sink_hold - 1;
            end
            else
            begin
                g = sink_calm ? 0 : pick_gap();
                if (g > 0 && $urandom_range(0, 2) == 0)
                begin
                    m_tready  <= 1'b0;
                    sink_hold <= g - 1;
                end
                else
                begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin : stimulus
        longint unsigned n, k, s, p, idx;
        logic [SIDE_W-1:0] side;
        int unsigned pick;

        // smallest grids, empty grid, full 16-bit grid, odd centres and ring corners
        add_query(16'd1, 32'd1);
        add_query(16'd1, 32'd0);
        add_query(16'd1, 32'd2);
        add_query(16'd0, 32'd0);
        add_query(16'd0, 32'd1);
        add_query(16'd0, 32'hFFFF_FFFF);
        add_query(16'd2, 32'd1);
        add_query(16'd2, 32'd2);
        add_query(16'd2, 32'd3);
        add_query(16'd2, 32'd4);
        add_query(16'd2, 32'd5);
        add_query(16'd3, 32'd8);
        add_query(16'd3, 32'd9);
        add_query(16'd4, 32'd16);
        add_query(16'd5, 32'd13);
        add_query(16'd5, 32'd25);
        add_query(16'd65535, 32'd1);
        add_query(16'd65535, 32'd4294836225);
        add_query(16'd65535, 32'd4294836226);
        add_query(16'd65535, 32'hFFFF_FFFF);
        add_query(16'd65535, 32'd196603);
        add_query(16'd65534, 32'd4294705156);
        add_query(16'd65534, 32'd131067);
        add_query(16'hAAAA, 32'h5555_5555);

        for (int i = 0; i < 650; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                side = SIDE_W'($urandom_range(1, 40));
            else if (pick < 90)
                side = SIDE_W'($urandom_range(41, 1000));
            else
                side = SIDE_W'($urandom_range(1, 65535));
            n    = 64'(side);
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                // land on a ring corner or somewhere on a random ring
                k = 64'($urandom_range(0, 32'((n - 1) / 2)));
                s = n - 2 * k;
                if (s == 1)
                    p = 1;
                else
                    case ($urandom_range(0, 5))
                        0:       p = 1;
                        1:       p = s;
                        2:       p = 2 * s - 1;
                        3:       p = 3 * s - 2;
                        4:       p = 4 * s - 4;
                        default: p = 64'($urandom_range(1, 32'(4 * s - 4)));
                    endcase
                idx = ring_start(n, k) + p;
            end
            else if (pick < 85)
            begin
                idx = 64'($urandom_range(1, 32'(n * n)));
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: idx = 0;
                    1: idx = n * n + 1;
                    2:
                    begin
                        side = SIDE_W'($urandom());
                        idx  = 64'($urandom());
                    end
                    default:
                    begin
                        side = '0;
                        idx  = 64'($urandom());
                    end
                endcase
            end
            // now and then let the core drain completely before the next query
            add_query(side, INDEX_W'(idx), (i % 150) == 40);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_queries.size() != 0 || s_tvalid || expected_cells.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Ran %0d spiral queries: %0d cells located, %0d out-of-range rejects checked.",
                 queries_accepted, cells_checked, misses_checked);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("Timed out with %0d queries waiting and %0d results outstanding.",
                 pending_queries.size(), expected_cells.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
src/sitc_pkg.sv
src/sitc_mult.sv
src/sitc_edge.sv
src/spiral_index_to_coordinate_core.sv
dv/tb_top.sv
